FILE: hdl/bskc_pkg.sv
// Shared types and constants for the byte stream keystream cipher.
`default_nettype none

package bskc_pkg;

  localparam logic [63:0] LcgMult    = 64'h5851_F42D_4C95_7F2D;
  localparam logic [63:0] FnvMult    = 64'h0000_0100_0000_01B3;
  localparam logic [63:0] NarrowMask = 64'h0000_0000_FFFF_FFFF;
  localparam int          RotAmount  = 13;

  localparam int SboxDepth = 256;
  localparam int CfgIdxW   = 3;

  localparam logic [CfgIdxW-1:0] CfgKind    = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgNarrow  = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgInit    = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgKeyOne  = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgKeyTwo  = 3'd4;

  localparam logic OpLoad    = 1'b0;
  localparam logic OpEncrypt = 1'b1;

  typedef enum logic [1:0] {
    KindArx     = 2'd0,
    KindLcg     = 2'd1,
    KindSbox    = 2'd2,
    KindFeistel = 2'd3
  } kind_e;

  typedef struct packed {
    logic        start;
    logic        ack;
    logic        narrow;
    logic [63:0] a;
    logic [63:0] b;
    logic [63:0] c;
  } mul_req_t;

  typedef struct packed {
    logic        busy;
    logic        done;
    logic [63:0] result;
  } mul_rsp_t;

endpackage

`default_nettype wire

FILE: hdl/bskc_ram.sv
// Generic single-port-write, registered-read RAM.
`default_nettype none

module bskc_ram #(
  parameter int DataWidth = 8,
  parameter int Depth     = 256,
  localparam int AddrWidth = $clog2(Depth)
) (
  input  logic                 clk_i,
  input  logic                 we_i,
  input  logic [AddrWidth-1:0] waddr_i,
  input  logic [DataWidth-1:0] wdata_i,
  input  logic                 re_i,
  input  logic [AddrWidth-1:0] raddr_i,
  output logic [DataWidth-1:0] rdata_o
);

  logic [DataWidth-1:0] mem_q [Depth];
  logic [DataWidth-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

FILE: hdl/bskc_mul.sv
// Iterative 64-bit multiply-add built on one shared 32x32 multiplier.
`default_nettype none

module bskc_mul
  import bskc_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  mul_req_t req_i,
  output mul_rsp_t rsp_o
);

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StHi1  = 2'd1;
  localparam logic [1:0] StHi2  = 2'd2;
  localparam logic [1:0] StDone = 2'd3;

  logic [1:0]  step_q, step_d;
  logic [63:0] a_q, b_q, c_q;
  logic        narrow_q;
  logic [31:0] lo_q, hi_q, hi_d;
  logic [31:0] mul_x, mul_y;
  logic [63:0] prod;
  logic [63:0] sum;

  always_comb begin
    unique case (step_q)
      StHi1: begin
        mul_x = a_q[31:0];
        mul_y = b_q[63:32];
      end
      StHi2: begin
        mul_x = a_q[63:32];
        mul_y = b_q[31:0];
      end
      default: begin
        mul_x = req_i.a[31:0];
        mul_y = req_i.b[31:0];
      end
    endcase
    prod = mul_x * mul_y;
    sum  = {hi_q, lo_q} + c_q;
  end

  always_comb begin
    step_d = step_q;
    hi_d   = hi_q;
    unique case (step_q)
      StIdle: begin
        if (req_i.start) begin
          step_d = req_i.narrow ? StDone : StHi1;
          hi_d   = prod[63:32];
        end
      end
      StHi1: begin
        step_d = StHi2;
        hi_d   = hi_q + prod[31:0];
      end
      StHi2: begin
        step_d = StDone;
        hi_d   = hi_q + prod[31:0];
      end
      StDone: begin
        if (req_i.ack) begin
          step_d = StIdle;
        end
      end
      default: step_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= StIdle;
    end else begin
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hi_q <= hi_d;
    if (step_q == StIdle && req_i.start) begin
      a_q      <= req_i.a;
      b_q      <= req_i.b;
      c_q      <= req_i.c;
      narrow_q <= req_i.narrow;
      lo_q     <= prod[31:0];
    end
  end

  assign rsp_o.busy   = (step_q != StIdle);
  assign rsp_o.done   = (step_q == StDone);
  assign rsp_o.result = narrow_q ? (sum & NarrowMask) : sum;

endmodule

`default_nettype wire

FILE: hdl/byte_stream_keystream_cipher_top.sv
// Top level of the byte stream keystream cipher.
`default_nettype none

// Items arrive on the s_axis stream: tuser bit 0 selects a table load or an encrypt,
// tuser bit 1 reloads the initial state, tdata carries the table index and the byte.
// A table load writes one entry of the substitution RAM and gives no result.
// Each encrypt gives one cipher byte on the m_axis stream.
// Registers are written on the cfg channel, which is always ready; the user is to write
// them only while the block is idle, and the block itself does not enforce this.
// An item sits in one working stage after it is accepted. A table load leaves that
// stage at once; an ARX encrypt leaves as soon as the output buffer has room, which
// registers its result. The other three kinds step the state through a multiply-add
// built on one shared 32x32 multiplier: the low product, then in 64-bit mode two cross
// products, and they leave once it is done and the output buffer has room.
// That multiplier in the state feedback loop sets the rate of those kinds.
// Reset clears the running state and the registers (key_one becomes 1);
// the substitution table is undefined until loaded, with no clearing pass.
// A two-entry output buffer absorbs a stalled receiver; when it is full, an encrypt in the
// working stage holds its item and s_axis_tready falls.

module byte_stream_keystream_cipher_top
  import bskc_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [15:0]        s_axis_tdata,  // table_index, data_byte
  input  logic [1:0]         s_axis_tuser,  // opcode, restart
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  output logic [7:0]         m_axis_tdata,  // cipher_byte
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [63:0]        cfg_data_i
);

  kind_e       kind_q;
  logic        narrow_q;
  logic [63:0] init_q, key1_q, key2_q;
  logic [63:0] state_q, state_d;

  logic        s1_valid_q, s1_run_q, s1_run_d;
  logic        s1_op_q, s1_restart_q;
  logic [7:0]  s1_pt_q;
  logic [7:0]  ct_pre_q, ct_pre_d;

  logic        accept, leave, push, pop, ob_free;
  logic [7:0]  ob_in;
  logic [7:0]  ob_q [2];
  logic        wr_ptr_q, rd_ptr_q;
  logic [1:0]  count_q;

  logic [7:0]  sbox_rdata;
  logic [63:0] mask, st0, arx_sum, arx_rot;
  logic        mul_start, mul_ack;
  mul_req_t    mul_req;
  mul_rsp_t    mul_rsp;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kind_q   <= KindArx;
      narrow_q <= 1'b0;
      init_q   <= '0;
      key1_q   <= 64'd1;
      key2_q   <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CfgKind:   kind_q   <= kind_e'(cfg_data_i[1:0]);
        CfgNarrow: narrow_q <= cfg_data_i[0];
        CfgInit:   init_q   <= cfg_data_i;
        CfgKeyOne: key1_q   <= cfg_data_i;
        CfgKeyTwo: key2_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign accept = s_axis_tvalid && s_axis_tready;

  bskc_ram #(
    .DataWidth(8),
    .Depth    (SboxDepth)
  ) u_sbox (
    .clk_i  (clk_i),
    .we_i   (accept && (s_axis_tuser[0] == OpLoad)),
    .waddr_i(s_axis_tdata[7:0]),
    .wdata_i(s_axis_tdata[15:8]),
    .re_i   (accept && (s_axis_tuser[0] == OpEncrypt)),
    .raddr_i(s_axis_tdata[15:8]),
    .rdata_o(sbox_rdata)
  );

  always_comb begin
    mask    = narrow_q ? NarrowMask : '1;
    st0     = (s1_restart_q ? init_q : state_q) & mask;
    arx_sum = (st0 + key1_q) & mask;
    if (narrow_q) begin
      arx_rot = {32'b0, arx_sum[31-RotAmount:0], arx_sum[31:32-RotAmount]};
    end else begin
      arx_rot = {arx_sum[63-RotAmount:0], arx_sum[63:64-RotAmount]};
    end
  end

  always_comb begin
    mul_req.start  = mul_start;
    mul_req.ack    = mul_ack;
    mul_req.a      = st0;
    mul_req.narrow = narrow_q;
    case (kind_q)
      KindLcg: begin
        mul_req.b = LcgMult;
        mul_req.c = key1_q;
      end
      KindSbox: begin
        mul_req.b = FnvMult;
        mul_req.c = key1_q;
      end
      default: begin
        mul_req.b = key1_q;
        mul_req.c = key2_q;
      end
    endcase
  end

  bskc_mul u_mul (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (mul_req),
    .rsp_o (mul_rsp)
  );

  assign ob_free = (count_q != 2'd2);

  always_comb begin
    push      = 1'b0;
    ob_in     = '0;
    leave     = 1'b0;
    state_d   = state_q;
    mul_start = 1'b0;
    mul_ack   = 1'b0;
    s1_run_d  = s1_run_q;
    ct_pre_d  = ct_pre_q;
    if (s1_valid_q) begin
      if (s1_op_q == OpLoad) begin
        leave = 1'b1;
      end else if (kind_q == KindArx) begin
        if (ob_free) begin
          push    = 1'b1;
          ob_in   = s1_pt_q ^ arx_rot[7:0];
          state_d = arx_rot;
          leave   = 1'b1;
        end
      end else if (!s1_run_q) begin
        mul_start = 1'b1;
        s1_run_d  = 1'b1;
        ct_pre_d  = (kind_q == KindSbox) ? (sbox_rdata + st0[7:0]) : (s1_pt_q ^ st0[7:0]);
      end else if (mul_rsp.done && ob_free) begin
        push     = 1'b1;
        ob_in    = (kind_q == KindLcg) ? (s1_pt_q + mul_rsp.result[7:0]) : ct_pre_q;
        state_d  = mul_rsp.result;
        mul_ack  = 1'b1;
        s1_run_d = 1'b0;
        leave    = 1'b1;
      end
    end
  end

  assign s_axis_tready = !s1_valid_q || leave;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s1_run_q   <= 1'b0;
      state_q    <= '0;
    end else begin
      s1_run_q <= s1_run_d;
      state_q  <= state_d;
      if (accept) begin
        s1_valid_q <= 1'b1;
      end else if (leave) begin
        s1_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    ct_pre_q <= ct_pre_d;
    if (accept) begin
      s1_op_q      <= s_axis_tuser[0];
      s1_restart_q <= s_axis_tuser[1];
      s1_pt_q      <= s_axis_tdata[15:8];
    end
  end

  assign pop           = m_axis_tvalid && m_axis_tready;
  assign m_axis_tvalid = (count_q != 2'd0);
  assign m_axis_tdata  = ob_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      case ({push, pop})
        2'b10:   count_q <= count_q + 2'd1;
        2'b01:   count_q <= count_q - 2'd1;
        default: count_q <= count_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      ob_q[wr_ptr_q] <= ob_in;
    end
  end

`ifndef SYNTHESIS
  a_ob_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q != 2'd3)
    else $error("Output buffer count went out of range.");

  a_mul_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_req.start |-> !mul_rsp.busy)
    else $error("Multiply-add started while still busy.");

  a_hold_in_mul: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && s1_run_q && !mul_rsp.done) |-> !s_axis_tready)
    else $error("Input accepted while a state update is in flight.");

  a_state_only_on_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !push |=> $stable(state_q))
    else $error("Running state changed without a result.");
`endif

endmodule

`default_nettype wire
